// ----- src/vmdc_pkg.sv -----
// shared types, codes and helper functions for the ventilation mode and duty controller
`timescale 1ns / 1ps

package vmdc_pkg;

    // operation codes
    localparam logic [1:0] OP_GESTURE = 2'd0;
    localparam logic [1:0] OP_SENSOR  = 2'd1;
    localparam logic [1:0] OP_POT     = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // gesture codes
    localparam logic [2:0] GEST_OTHER  = 3'd0;
    localparam logic [2:0] GEST_UP     = 3'd1;
    localparam logic [2:0] GEST_DOWN   = 3'd2;
    localparam logic [2:0] GEST_LEFT   = 3'd3;
    localparam logic [2:0] GEST_RIGHT  = 3'd4;
    localparam logic [2:0] GEST_CENTER = 3'd5;
    localparam logic [2:0] GEST_LONG   = 3'd6;

    // led codes
    localparam logic [1:0] LED_NONE  = 2'd0;
    localparam logic [1:0] LED_RED   = 2'd1;
    localparam logic [1:0] LED_GREEN = 2'd2;
    localparam logic [1:0] LED_BLUE  = 2'd3;

    // duty levels in percent
    localparam logic [6:0] DUTY_OFF  = 7'd0;
    localparam logic [6:0] DUTY_LOW  = 7'd10;
    localparam logic [6:0] DUTY_MID  = 7'd40;
    localparam logic [6:0] DUTY_HIGH = 7'd70;
    localparam logic [6:0] DUTY_FULL = 7'd100;

    // temperature limits, 1/16 degC
    localparam logic signed [11:0] TEMP_MAX  = 12'sd480;
    localparam logic signed [11:0] TEMP_MIN  = 12'sd32;
    localparam logic signed [11:0] TEMP_STEP = 12'sd8;
    localparam logic signed [11:0] TEMP_INIT = 12'sd352;
    localparam logic signed [11:0] THR_INIT  = 12'sd64;

    // error bands
    localparam logic signed [13:0] BAND_HI  = 14'sd80;
    localparam logic signed [13:0] BAND_MID = 14'sd32;
    localparam logic signed [13:0] BAND_LO  = 14'sd8;

    // time limits
    localparam logic [4:0] HOURS_MAX  = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         gesture;
        logic signed [11:0] inside_temp;
        logic signed [11:0] outside_temp;
        logic signed [11:0] threshold_in;
        logic [4:0]         clock_hours;
        logic [5:0]         clock_minutes;
        logic [5:0]         clock_seconds;
    } req_t;

    typedef struct packed {
        logic [1:0]         mode_now;
        logic               duty_valid;
        logic [6:0]         duty_percent;
        logic [1:0]         led_color;
        logic               alarm_on;
        logic [8:0]         setpoint_now;
        logic signed [11:0] threshold_now;
        logic               time_write;
        logic [4:0]         write_hours;
        logic [5:0]         write_minutes;
        logic [5:0]         write_seconds;
    } res_t;

    typedef struct packed {
        logic [6:0] duty;
        logic [1:0] led;
    } band_t;

    // half degree step; no step up at or above the maximum, none down at or below the minimum
    function automatic logic signed [11:0] step_temp(input logic signed [11:0] t,
                                                     input logic up);
        logic signed [11:0] r;
        r = t;
        if (up)
        begin
            if (t < TEMP_MAX)
                r = t + TEMP_STEP;
        end
        else if (t > TEMP_MIN)
        begin
            r = t - TEMP_STEP;
        end
        return r;
    endfunction

    // setpoint error to duty and led
    function automatic band_t error_band(input logic signed [13:0] x);
        band_t b;
        if (x >= BAND_HI)
            b = '{duty: DUTY_FULL, led: LED_RED};
        else if (x >= BAND_MID)
            b = '{duty: DUTY_HIGH, led: LED_RED};
        else if (x >= BAND_LO)
            b = '{duty: DUTY_MID, led: LED_RED};
        else if (x > -BAND_LO)
            b = '{duty: DUTY_LOW, led: LED_GREEN};
        else if (x > -BAND_MID)
            b = '{duty: DUTY_MID, led: LED_BLUE};
        else if (x > -BAND_HI)
            b = '{duty: DUTY_HIGH, led: LED_BLUE};
        else
            b = '{duty: DUTY_FULL, led: LED_BLUE};
        return b;
    endfunction

endpackage

// ----- src/vmdc_ifs.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps

interface vmdc_req_if;
    logic          valid;
    logic          ready;
    vmdc_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vmdc_res_if;
    logic          valid;
    logic          ready;
    vmdc_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/vmdc_in_stage.sv -----
// input register stage for requests
`timescale 1ns / 1ps

module vmdc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    vmdc_req_if.sink       req,
    input  logic           core_ready,
    output logic           stage_valid,
    output vmdc_pkg::req_t stage_data
);

    logic           valid_reg;
    logic           valid_next;
    vmdc_pkg::req_t data_reg;
    logic           take;

    assign req.ready   = !valid_reg || core_ready;
    assign take        = req.valid && req.ready;
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (core_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= req.data;
    end

endmodule

// ----- src/vmdc_core.sv -----
// mode machine, edit copy, duty bands and result register
`timescale 1ns / 1ps

module vmdc_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           stage_valid,
    input  vmdc_pkg::req_t stage_data,
    output logic           core_ready,
    vmdc_res_if.source     res
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_TEST   = 2'd2,
        MODE_EDIT   = 2'd3
    } mode_t;

    localparam logic [2:0] FIELD_HOURS   = 3'd0;
    localparam logic [2:0] FIELD_MINUTES = 3'd1;
    localparam logic [2:0] FIELD_SECONDS = 3'd2;
    localparam logic [2:0] FIELD_SETPT   = 3'd3;
    localparam logic [2:0] FIELD_LAST    = 3'd4;

    mode_t              mode_reg, mode_next;
    logic [8:0]         setpoint_reg, setpoint_next;
    logic signed [11:0] threshold_reg, threshold_next;
    logic signed [11:0] inside_reg, inside_next;
    logic signed [11:0] outside_reg, outside_next;
    logic [8:0]         test_inside_reg, test_inside_next;
    logic               alarm_reg, alarm_next;
    logic [4:0]         edit_hours_reg, edit_hours_next;
    logic [5:0]         edit_minutes_reg, edit_minutes_next;
    logic [5:0]         edit_seconds_reg, edit_seconds_next;
    logic [8:0]         edit_setpoint_reg, edit_setpoint_next;
    logic signed [11:0] edit_threshold_reg, edit_threshold_next;
    logic [2:0]         edit_cursor_reg, edit_cursor_next;
    logic               edit_fresh_reg, edit_fresh_next;
    logic               out_valid_reg, out_valid_next;
    vmdc_pkg::res_t     res_reg, res_next;

    logic               advance;
    logic               is_up;
    logic signed [13:0] err;
    vmdc_pkg::band_t    band;

    assign core_ready = !out_valid_reg || res.ready;
    assign advance    = stage_valid && core_ready;
    assign res.valid  = out_valid_reg;
    assign res.data   = res_reg;
    assign is_up      = (stage_data.gesture == vmdc_pkg::GEST_UP);

    // setpoint error against measured or test inside temperature
    assign err = $signed({5'b0, setpoint_reg})
               - ((mode_reg == MODE_TEST) ? $signed({5'b0, test_inside_reg})
                                          : {{2{inside_reg[11]}}, inside_reg});
    assign band = vmdc_pkg::error_band(err);

    always_comb
    begin
        mode_next           = mode_reg;
        setpoint_next       = setpoint_reg;
        threshold_next      = threshold_reg;
        inside_next         = inside_reg;
        outside_next        = outside_reg;
        test_inside_next    = test_inside_reg;
        alarm_next          = alarm_reg;
        edit_hours_next     = edit_hours_reg;
        edit_minutes_next   = edit_minutes_reg;
        edit_seconds_next   = edit_seconds_reg;
        edit_setpoint_next  = edit_setpoint_reg;
        edit_threshold_next = edit_threshold_reg;
        edit_cursor_next    = edit_cursor_reg;
        edit_fresh_next     = edit_fresh_reg;
        res_next            = '0;

        case (stage_data.operation)
            vmdc_pkg::OP_GESTURE:
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (stage_data.gesture == vmdc_pkg::GEST_LONG)
                            mode_next = MODE_ACTIVE;
                    end
                    MODE_ACTIVE:
                    begin
                        case (stage_data.gesture)
                            vmdc_pkg::GEST_UP, vmdc_pkg::GEST_DOWN:
                                setpoint_next = 9'(vmdc_pkg::step_temp(
                                    $signed({3'b0, setpoint_reg}), is_up));
                            vmdc_pkg::GEST_CENTER: mode_next = MODE_TEST;
                            vmdc_pkg::GEST_LONG:   mode_next = MODE_IDLE;
                            default: ;
                        endcase
                    end
                    MODE_TEST:
                    begin
                        case (stage_data.gesture)
                            vmdc_pkg::GEST_RIGHT:
                                test_inside_next = 9'(vmdc_pkg::step_temp(
                                    $signed({3'b0, test_inside_reg}), 1'b1));
                            vmdc_pkg::GEST_LEFT:
                                test_inside_next = 9'(vmdc_pkg::step_temp(
                                    $signed({3'b0, test_inside_reg}), 1'b0));
                            vmdc_pkg::GEST_UP, vmdc_pkg::GEST_DOWN:
                                setpoint_next = 9'(vmdc_pkg::step_temp(
                                    $signed({3'b0, setpoint_reg}), is_up));
                            vmdc_pkg::GEST_CENTER: mode_next = MODE_EDIT;
                            vmdc_pkg::GEST_LONG:   mode_next = MODE_IDLE;
                            default: ;
                        endcase
                    end
                    MODE_EDIT:
                    begin
                        // first gesture in edit takes the working copy
                        if (edit_fresh_reg)
                        begin
                            edit_hours_next     = stage_data.clock_hours;
                            edit_minutes_next   = stage_data.clock_minutes;
                            edit_seconds_next   = stage_data.clock_seconds;
                            edit_setpoint_next  = setpoint_reg;
                            edit_threshold_next = threshold_reg;
                            edit_cursor_next    = FIELD_HOURS;
                            edit_fresh_next     = 1'b0;
                        end
                        case (stage_data.gesture)
                            vmdc_pkg::GEST_RIGHT:
                                edit_cursor_next = (edit_cursor_next == FIELD_LAST)
                                                 ? FIELD_HOURS : edit_cursor_next + 3'd1;
                            vmdc_pkg::GEST_LEFT:
                                edit_cursor_next = (edit_cursor_next == FIELD_HOURS)
                                                 ? FIELD_LAST : edit_cursor_next - 3'd1;
                            vmdc_pkg::GEST_UP, vmdc_pkg::GEST_DOWN:
                            begin
                                case (edit_cursor_next)
                                    FIELD_HOURS:
                                    begin
                                        if (is_up && edit_hours_next < vmdc_pkg::HOURS_MAX)
                                            edit_hours_next = edit_hours_next + 5'd1;
                                        else if (!is_up && edit_hours_next != 5'd0)
                                            edit_hours_next = edit_hours_next - 5'd1;
                                    end
                                    FIELD_MINUTES:
                                    begin
                                        if (is_up && edit_minutes_next < vmdc_pkg::MINSEC_MAX)
                                            edit_minutes_next = edit_minutes_next + 6'd1;
                                        else if (!is_up && edit_minutes_next != 6'd0)
                                            edit_minutes_next = edit_minutes_next - 6'd1;
                                    end
                                    FIELD_SECONDS:
                                    begin
                                        if (is_up && edit_seconds_next < vmdc_pkg::MINSEC_MAX)
                                            edit_seconds_next = edit_seconds_next + 6'd1;
                                        else if (!is_up && edit_seconds_next != 6'd0)
                                            edit_seconds_next = edit_seconds_next - 6'd1;
                                    end
                                    FIELD_SETPT:
                                        edit_setpoint_next = 9'(vmdc_pkg::step_temp(
                                            $signed({3'b0, edit_setpoint_next}), is_up));
                                    default:
                                        edit_threshold_next = vmdc_pkg::step_temp(
                                            edit_threshold_next, is_up);
                                endcase
                            end
                            vmdc_pkg::GEST_CENTER:
                            begin
                                res_next.time_write    = 1'b1;
                                res_next.write_hours   = edit_hours_next;
                                res_next.write_minutes = edit_minutes_next;
                                res_next.write_seconds = edit_seconds_next;
                                setpoint_next          = edit_setpoint_next;
                                threshold_next         = edit_threshold_next;
                            end
                            vmdc_pkg::GEST_LONG:
                            begin
                                mode_next       = MODE_IDLE;
                                edit_fresh_next = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
            vmdc_pkg::OP_SENSOR:
            begin
                inside_next  = stage_data.inside_temp;
                outside_next = stage_data.outside_temp;
            end
            vmdc_pkg::OP_POT:
            begin
                if (mode_reg == MODE_TEST)
                begin
                    outside_next   = stage_data.outside_temp;
                    threshold_next = stage_data.threshold_in;
                end
            end
            default:
            begin
                if (mode_reg == MODE_ACTIVE || mode_reg == MODE_TEST)
                begin
                    res_next.duty_valid   = 1'b1;
                    res_next.duty_percent = band.duty;
                    res_next.led_color    = band.led;
                    alarm_next            = (outside_reg < threshold_reg);
                end
            end
        endcase

        res_next.mode_now      = mode_next;
        res_next.alarm_on      = alarm_next;
        res_next.setpoint_now  = setpoint_next;
        res_next.threshold_now = threshold_next;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_IDLE;
            setpoint_reg       <= 9'(vmdc_pkg::TEMP_INIT);
            threshold_reg      <= vmdc_pkg::THR_INIT;
            inside_reg         <= vmdc_pkg::TEMP_INIT;
            outside_reg        <= vmdc_pkg::TEMP_INIT;
            test_inside_reg    <= 9'(vmdc_pkg::TEMP_INIT);
            alarm_reg          <= 1'b0;
            edit_hours_reg     <= 5'd0;
            edit_minutes_reg   <= 6'd0;
            edit_seconds_reg   <= 6'd0;
            edit_setpoint_reg  <= 9'(vmdc_pkg::TEMP_INIT);
            edit_threshold_reg <= vmdc_pkg::THR_INIT;
            edit_cursor_reg    <= FIELD_HOURS;
            edit_fresh_reg     <= 1'b1;
            out_valid_reg      <= 1'b0;
            res_reg            <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg           <= mode_next;
                setpoint_reg       <= setpoint_next;
                threshold_reg      <= threshold_next;
                inside_reg         <= inside_next;
                outside_reg        <= outside_next;
                test_inside_reg    <= test_inside_next;
                alarm_reg          <= alarm_next;
                edit_hours_reg     <= edit_hours_next;
                edit_minutes_reg   <= edit_minutes_next;
                edit_seconds_reg   <= edit_seconds_next;
                edit_setpoint_reg  <= edit_setpoint_next;
                edit_threshold_reg <= edit_threshold_next;
                edit_cursor_reg    <= edit_cursor_next;
                edit_fresh_reg     <= edit_fresh_next;
                res_reg            <= res_next;
            end
        end
    end

    // a clock load only comes from a save in edit mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res_reg.time_write) |-> (res_reg.mode_now == MODE_EDIT))
        else $error("time write outside edit mode");

    // a duty only comes out of active or test mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res_reg.duty_valid)
            |-> (res_reg.mode_now == MODE_ACTIVE || res_reg.mode_now == MODE_TEST))
        else $error("duty outside active or test mode");

    // setpoint stays within its limits after every request
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (setpoint_reg >= 9'd32 && setpoint_reg <= 9'd480))
        else $error("setpoint out of range");

    // every accepted request leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost");

    // cursor never leaves the five fields
    assert property (@(posedge clk) disable iff (!rst_n)
        $changed(edit_cursor_reg) |-> (edit_cursor_reg <= FIELD_LAST && $past(advance)))
        else $error("cursor out of range or moved without a request");

endmodule

// ----- src/ventilation_mode_and_duty_controller_top.sv -----
// top level of the ventilation mode and duty controller
`timescale 1ns / 1ps

// Takes one request per clock cycle (gesture, sensor sample, potentiometer
// sample or control tick) and returns exactly one result for each, in order.
// A request passes an input register and then a result register, where its result
// is offered; the result register is the only place that holds up the flow, and
// while it is taken every cycle the block takes a new request every cycle. The
// mode, setpoint, threshold, readings and the edit copy update as each request
// moves into the result register, so the next request already sees them.
module ventilation_mode_and_duty_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    vmdc_req_if.sink   req,
    vmdc_res_if.source res
);

    logic           core_ready;
    logic           stage_valid;
    vmdc_pkg::req_t stage_data;

    vmdc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .core_ready  (core_ready),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    vmdc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .core_ready  (core_ready),
        .res         (res)
    );

endmodule
